[rtl/dcs_pkg.sv]
package dcs_pkg;

  localparam int unsigned DIST_W  = 10;
  localparam int unsigned CTRL_W  = 7;
  localparam int unsigned LVL_W   = 11;
  localparam int unsigned OUT_W   = 7;
  localparam int unsigned NUM_W   = DIST_W + LVL_W;
  localparam int unsigned DEN_W   = DIST_W;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned CDATA_W = 10;

  localparam logic [STEP_W-1:0] TGT_STEPS = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] OUT_STEPS = STEP_W'(LVL_W);

  localparam logic [LVL_W-1:0] STEP_UP   = LVL_W'(10);
  localparam logic [LVL_W-1:0] STEP_DOWN = LVL_W'(2);
  localparam logic [LVL_W-1:0] OUT_MAX   = LVL_W'(127);

  localparam logic [CFG_W-1:0] CFG_MIN_DIST = 2'd0;
  localparam logic [CFG_W-1:0] CFG_MAX_DIST = 2'd1;
  localparam logic [CFG_W-1:0] CFG_CTRL_NUM = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_TGT,
    S_SLEW,
    S_DIV_OUT,
    S_SEND
  } dcs_state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

endpackage

[rtl/dcs_div.sv]
module dcs_div
  import dcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // one restoring step: bring down the next numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_d = {num_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  // quotient bits collect at the bottom of the numerator register
  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

[rtl/distance_to_controller_slew_core.sv]
// Distance to controller level with slew limiting.
// Input channel (in_valid_i/in_ready_o) takes one item: a distance and a
// direct-mode flag. Output channel (out_valid_o/out_ready_i) gives zero or one
// item per input: the configured controller number and a 7-bit level.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i):
// index 0 min distance, 1 max distance, 2 controller number.
// One item at a time goes through a sequencer that shares one restoring
// divider: a multiply state, 21 steps for the target quotient, a slew
// state, 11 steps for the output scaling and a send state.
// When the target is clamped the first divide is skipped, and a slew-mode
// item whose target equals the slewed level skips the second divide and
// sends no result.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is already being worked on, and the block waits only
// when a new result is ready and the register is still full.
// Reset clears the slewed level to 0 and loads the register defaults
// (min 0, max 300, controller 0).
module distance_to_controller_slew_core
  import dcs_pkg::*;
#(
  parameter int unsigned FULL_LEVEL = 1270
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_idx_i,
  input  logic [CDATA_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DIST_W-1:0]  distance_i,
  input  logic               direct_mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CTRL_W-1:0]  controller_o,
  output logic [OUT_W-1:0]   level_o
);

  localparam logic [LVL_W-1:0] FULL_LVL  = LVL_W'(FULL_LEVEL);
  localparam logic [DEN_W-1:0] SCALE_DIV = DEN_W'(FULL_LEVEL / 127);

  dcs_state_e state_q, state_d;

  logic [DIST_W-1:0] min_q, max_q;
  logic [CTRL_W-1:0] ctrl_q;
  logic [DIST_W-1:0] dist_q;
  logic              direct_q;
  logic [LVL_W-1:0]  tgt_q;
  logic [LVL_W-1:0]  slewed_q;
  logic              out_valid_q;
  logic [CTRL_W-1:0] out_ctrl_q;
  logic [OUT_W-1:0]  out_lvl_q;

  div_req_t          req;
  logic              div_done;
  logic [NUM_W-1:0]  quo;

  logic              clamp_full, clamp_zero;
  logic [DIST_W-1:0] span_hi;
  logic [NUM_W-1:0]  prod;
  logic [LVL_W:0]    up_sum;
  logic [LVL_W-1:0]  slew_next;
  logic              changed;
  logic [LVL_W-1:0]  send_lvl;
  logic [OUT_W-1:0]  scaled;
  logic              out_free;
  logic              accept;
  logic              load_out;

  dcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // target: below min or an inverted range saturate high, at or past max give zero
  always_comb begin
    clamp_full = (dist_q < min_q) || (max_q < min_q);
    clamp_zero = (dist_q >= max_q);
    span_hi    = max_q - dist_q;
    prod       = NUM_W'(span_hi) * NUM_W'(FULL_LVL);
  end

  always_comb begin
    up_sum    = {1'b0, slewed_q} + {1'b0, STEP_UP};
    slew_next = slewed_q;
    changed   = 1'b1;
    if (tgt_q > slewed_q) begin
      slew_next = (up_sum > {1'b0, FULL_LVL}) ? FULL_LVL : up_sum[LVL_W-1:0];
    end else if (tgt_q < slewed_q) begin
      slew_next = (slewed_q < STEP_DOWN) ? '0 : slewed_q - STEP_DOWN;
    end else begin
      changed = direct_q;
    end
    send_lvl = direct_q ? tgt_q : slew_next;
  end

  assign scaled   = (quo[LVL_W-1:0] > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : quo[OUT_W-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_MUL;
      S_MUL:     state_d = (clamp_full || clamp_zero) ? S_SLEW : S_DIV_TGT;
      S_DIV_TGT: if (div_done) state_d = S_SLEW;
      S_SLEW:    state_d = changed ? S_DIV_OUT : S_IDLE;
      S_DIV_OUT: if (div_done) state_d = S_SEND;
      S_SEND:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    req        = '0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_MUL: begin
        req.start = !(clamp_full || clamp_zero);
        req.steps = TGT_STEPS;
        req.num   = prod;
        req.den   = max_q - min_q;
      end
      S_SLEW: begin
        req.start = changed;
        req.steps = OUT_STEPS;
        req.num   = {send_lvl, {(NUM_W-LVL_W){1'b0}}};
        req.den   = SCALE_DIV;
      end
      S_SEND:  load_out = out_free;
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= '0;
      max_q       <= DIST_W'(300);
      ctrl_q      <= '0;
      slewed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_DIST: min_q  <= cfg_wdata_i[DIST_W-1:0];
          CFG_MAX_DIST: max_q  <= cfg_wdata_i[DIST_W-1:0];
          CFG_CTRL_NUM: ctrl_q <= cfg_wdata_i[CTRL_W-1:0];
          default: ;
        endcase
      end
      // direct mode leaves the slewed level alone
      if (state_q == S_SLEW && !direct_q) slewed_q <= slew_next;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dist_q   <= distance_i;
      direct_q <= direct_mode_i;
    end
    if (state_q == S_MUL) tgt_q <= clamp_full ? FULL_LVL : '0;
    if (state_q == S_DIV_TGT && div_done) tgt_q <= quo[LVL_W-1:0];
    if (load_out) begin
      out_ctrl_q <= ctrl_q;
      out_lvl_q  <= scaled;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign controller_o = out_ctrl_q;
  assign level_o      = out_lvl_q;

endmodule

[dv/distance_to_controller_slew_core_tb.sv]
module distance_to_controller_slew_core_tb;
  import dcs_pkg::*;

  localparam int FULL       = 1270;
  localparam int CC_MAX     = 127;
  localparam int PERIOD_HI  = 10;
  localparam int PERIOD_LO  = 10;
  localparam int STALL_LEN  = 900;
  localparam int WDOG_LIMIT = 3000;
  localparam int TAIL       = 60;
  localparam int RAND_SETS  = 8;
  localparam int SET_ITEMS  = 250;
  localparam logic [CFG_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [DIST_W-1:0] range_cm;
    logic              direct;
  } reading_t;

  typedef struct {
    logic [CTRL_W-1:0] controller;
    logic [OUT_W-1:0]  level;
  } cc_msg_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [CFG_W-1:0]   cfg_idx      = '0;
  logic [CDATA_W-1:0] cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [DIST_W-1:0]  in_distance  = '0;
  logic               in_direct    = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [CTRL_W-1:0]  controller;
  logic [OUT_W-1:0]   level;

  logic steady     = 1'b0;
  logic hold_go    = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  reading_t distance_queue[$];
  cc_msg_t  cc_expected[$];

  // copy of the block's registers and slew state
  int                model_min  = 0;
  int                model_max  = 300;
  logic [CTRL_W-1:0] model_ctrl = '0;
  int                slew_state = 0;

  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int quiet_cycles    = 0;

  distance_to_controller_slew_core #(
    .FULL_LEVEL(FULL)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .distance_i   (in_distance),
    .direct_mode_i(in_direct),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .controller_o (controller),
    .level_o      (level)
  );

  always begin
    #PERIOD_HI clk_i = 1'b1;
    #PERIOD_LO clk_i = 1'b0;
  end

  function automatic int target_level_of(logic [DIST_W-1:0] d);
    longint span;
    longint num;
    longint q;
    span = longint'(model_max) - longint'(model_min);
    num  = (longint'(model_max) - longint'(d)) * FULL;
    q    = (span != 0) ? num / span : 0;
    if (int'(d) < model_min) q = FULL;
    if (q > FULL) q = FULL;
    if (q < 0) q = 0;
    return int'(q);
  endfunction

  function automatic logic [OUT_W-1:0] scale_to_cc(int lvl);
    int div;
    int v;
    div = FULL / CC_MAX;
    if (div < 1) div = 1;
    v = lvl / div;
    if (v > CC_MAX) v = CC_MAX;
    if (v < 0) v = 0;
    return OUT_W'(v);
  endfunction

  function automatic void predict_cc(logic [DIST_W-1:0] d, logic direct);
    int      tgt;
    int      lvl;
    bit      moved;
    cc_msg_t msg;
    tgt   = target_level_of(d);
    moved = 1'b1;
    if (direct) begin
      lvl = tgt;
    end else begin
      if (tgt > slew_state) slew_state += 10;
      else if (tgt < slew_state) slew_state -= 2;
      else moved = 1'b0;
      if (slew_state > FULL) slew_state = FULL;
      if (slew_state < 0) slew_state = 0;
      lvl = slew_state;
    end
    if (moved) begin
      msg.controller = model_ctrl;
      msg.level      = scale_to_cc(lvl);
      cc_expected.push_back(msg);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 25) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // write all three registers on consecutive edges; optionally poke the unused index
  task automatic write_regs(input logic [CDATA_W-1:0] mn, input logic [CDATA_W-1:0] mx,
                            input logic [CDATA_W-1:0] cn, input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MIN_DIST;
    cfg_wdata <= mn;
    @(posedge clk_i);
    cfg_idx   <= CFG_MAX_DIST;
    cfg_wdata <= mx;
    @(posedge clk_i);
    cfg_idx   <= CFG_CTRL_NUM;
    cfg_wdata <= cn;
    @(posedge clk_i);
    if (poke_spare) begin
      cfg_idx   <= CFG_SPARE;
      cfg_wdata <= CDATA_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we     <= 1'b0;
    model_min  = int'(mn);
    model_max  = int'(mx);
    model_ctrl = cn[CTRL_W-1:0];
    settings_used++;
  endtask

  task automatic add_reading(input int d, input bit direct);
    reading_t r;
    r.range_cm = DIST_W'(d);
    r.direct   = direct;
    distance_queue.push_back(r);
  endtask

  task automatic drain;
    while (distance_queue.size() != 0 || in_valid || cc_expected.size() != 0)
      @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  // sender: offer the next reading, hold it until taken
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    reading_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_cc(in_distance, in_direct);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (distance_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 36)) begin
          nxt = distance_queue.pop_front();
          in_valid    <= 1'b1;
          in_distance <= nxt.range_cm;
          in_direct   <= nxt.direct;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result, stall at random or for one long stretch
  always @(posedge clk_i or negedge rst_ni) begin : check_p
    cc_msg_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (cc_expected.size() == 0) begin
          report_mismatch("unexpected result, level", int'(level), -1);
        end else begin
          want = cc_expected.pop_front();
          if (controller !== want.controller)
            report_mismatch("controller", int'(controller), int'(want.controller));
          if (level !== want.level)
            report_mismatch("level", int'(level), int'(want.level));
        end
      end
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= STALL_LEN;
        out_ready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", WDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stim_p
    int mn;
    int mx;
    int lo;
    int hi;
    int d;
    int len;
    int added;
    int kind;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: both edges of the band, both modes, slew up and down
    write_regs(10'd100, 10'd400, 10'h055, 1'b1);
    add_reading(0, 1'b1);
    add_reading(99, 1'b1);
    add_reading(100, 1'b1);
    add_reading(101, 1'b1);
    add_reading(250, 1'b1);
    add_reading(399, 1'b1);
    add_reading(400, 1'b1);
    add_reading(401, 1'b1);
    add_reading(1023, 1'b1);
    repeat (4) add_reading(0, 1'b0);
    repeat (3) add_reading(1023, 1'b0);
    add_reading(400, 1'b0);
    drain();

    // full range, upper data bits set on the controller write
    write_regs(10'd0, 10'd1023, 10'h3FF, 1'b0);
    add_reading(0, 1'b1);
    add_reading(1023, 1'b1);
    add_reading(512, 1'b0);
    drain();

    // maximum below minimum
    write_regs(10'd1023, 10'd0, 10'd0, 1'b0);
    add_reading(0, 1'b1);
    add_reading(1023, 1'b1);
    add_reading(1022, 1'b0);
    drain();

    // equal minimum and maximum
    write_regs(10'd500, 10'd500, 10'd64, 1'b0);
    add_reading(499, 1'b1);
    add_reading(500, 1'b1);
    add_reading(501, 1'b0);
    drain();

    for (int s = 0; s < RAND_SETS; s++) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        mn = $urandom_range(0, 1023);
        mx = $urandom_range(0, 1023);
      end else if (kind < 40) begin
        mn = $urandom_range(0, 1000);
        mx = mn + $urandom_range(1, 20);
      end else if (kind < 55) begin
        mx = $urandom_range(0, 900);
        mn = mx + $urandom_range(1, 123);
      end else if (kind < 65) begin
        mn = $urandom_range(0, 1023);
        mx = mn;
      end else begin
        mn = $urandom_range(0, 200);
        mx = mn + $urandom_range(100, 600);
      end
      write_regs(CDATA_W'(mn), CDATA_W'(mx), CDATA_W'($urandom), s == 3);
      steady  <= (s == 5);
      hold_go <= (s == 2);

      lo = ((mn < mx) ? mn : mx) - 8;
      hi = ((mn < mx) ? mx : mn) + 8;
      if (lo < 0) lo = 0;
      if (hi > 1023) hi = 1023;
      added = 0;
      // runs of one distance let the slewed level climb all the way or fall far
      while (added < SET_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) d = $urandom_range(0, 1023);
        else if (kind < 80) d = $urandom_range(lo, hi);
        else if (kind < 90) d = 0;
        else d = 1023;
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
        for (int j = 0; j < len && added < SET_ITEMS; j++) begin
          add_reading(d, $urandom_range(0, 6) == 0);
          added++;
        end
      end
      drain();
    end

    if (cc_expected.size() != 0)
      report_mismatch("results never produced", 0, cc_expected.size());
    $display("Covered %0d items over %0d register settings, %0d results checked",
             items_sent, settings_used, results_checked);
    $display("including a long receiver stall and direct and slew modes throughout");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
